FILE: rtl/core/scim_pkg.sv
package scim_pkg;

  localparam int MAX_COPIES = 8;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W  = 24;
  localparam int COL_W  = 8;
  localparam int ROW_W  = 8;
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CNT_W  = 4;
  localparam int IDX_W  = 3;
  localparam int DIM_W  = 9;
  localparam int PADDR_W = 6;
  localparam int PDATA_W = 64;

  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  localparam logic [2:0] REG_POINT_COUNT  = 3'd0;
  localparam logic [2:0] REG_COLOR_SPLIT  = 3'd1;
  localparam logic [2:0] REG_ALPHA        = 3'd2;
  localparam logic [2:0] REG_X_OFFSETS    = 3'd3;
  localparam logic [2:0] REG_Y_OFFSETS    = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH  = 3'd5;
  localparam logic [2:0] REG_FRAME_HEIGHT = 3'd6;
  localparam logic [2:0] REG_OUTPUT_BLEND = 3'd7;

  localparam logic [1:0] BLEND_REPLACE  = 2'd0;
  localparam logic [1:0] BLEND_ADD      = 2'd1;
  localparam logic [1:0] BLEND_MEAN     = 2'd2;
  localparam logic [1:0] BLEND_MEAN_ALT = 2'd3;

  typedef struct packed {
    logic [CNT_W-1:0] point_count;
    logic             color_split;
    logic [7:0]       alpha;
    logic [63:0]      x_offsets;
    logic [63:0]      y_offsets;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [1:0]       output_blend;
  } scim_cfg_t;

  typedef struct packed {
    logic             wr;
    logic             start;
    logic             rd_copy;
    logic [IDX_W-1:0] copy_idx;
    logic             out_load;
  } scim_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
  } scim_stat_t;

endpackage

FILE: rtl/core/scim_if.sv
interface scim_in_if;
  import scim_pkg::*;
  logic             valid;
  logic             ready;
  logic             kind;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, kind, col, row, pixel_in, input ready);
  modport sink   (input valid, kind, col, row, pixel_in, output ready);
endinterface

interface scim_out_if;
  import scim_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

FILE: rtl/core/scim_regs.sv
module scim_regs
  import scim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output scim_cfg_t          cfg_o
);

  scim_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.point_count  <= CNT_W'(2);
      cfg_q.color_split  <= 1'b1;
      cfg_q.alpha        <= 8'd128;
      cfg_q.x_offsets    <= '0;
      cfg_q.y_offsets    <= '0;
      cfg_q.frame_width  <= DIM_W'(256);
      cfg_q.frame_height <= DIM_W'(256);
      cfg_q.output_blend <= BLEND_REPLACE;
    end else if (wr_en) begin
      unique case (idx)
        REG_POINT_COUNT:  cfg_q.point_count  <= pwdata[CNT_W-1:0];
        REG_COLOR_SPLIT:  cfg_q.color_split  <= pwdata[0];
        REG_ALPHA:        cfg_q.alpha        <= pwdata[7:0];
        REG_X_OFFSETS:    cfg_q.x_offsets    <= pwdata;
        REG_Y_OFFSETS:    cfg_q.y_offsets    <= pwdata;
        REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[DIM_W-1:0];
        REG_OUTPUT_BLEND: cfg_q.output_blend <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_POINT_COUNT:  prdata = PDATA_W'(cfg_q.point_count);
      REG_COLOR_SPLIT:  prdata = PDATA_W'(cfg_q.color_split);
      REG_ALPHA:        prdata = PDATA_W'(cfg_q.alpha);
      REG_X_OFFSETS:    prdata = cfg_q.x_offsets;
      REG_Y_OFFSETS:    prdata = cfg_q.y_offsets;
      REG_FRAME_WIDTH:  prdata = PDATA_W'(cfg_q.frame_width);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(cfg_q.frame_height);
      REG_OUTPUT_BLEND: prdata = PDATA_W'(cfg_q.output_blend);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/scim_ctrl.sv
module scim_ctrl
  import scim_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_kind_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  scim_stat_t stat_i,
  output scim_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_COPY  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             room;
  logic             last_copy;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign room       = !out_valid_q || out_ready_i;
  assign last_copy  = ({1'b0, cnt_q} == (stat_i.count - CNT_W'(1)));

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.copy_idx = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_LOAD) begin
            cmd_o.wr = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            cnt_d       = '0;
            state_d     = (stat_i.count == '0) ? ST_FLUSH : ST_COPY;
          end
        end
      end
      ST_COPY: begin
        cmd_o.rd_copy = 1'b1;
        cnt_d         = cnt_q + IDX_W'(1);
        if (last_copy) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (room) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |-> ({1'b0, cnt_q} < stat_i.count))
    else $error("copy counter beyond copy count");
  a_flush_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> (state_q == ST_DONE))
    else $error("flush not followed by done");
  a_load_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");
  a_result_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> (out_valid_q && state_q == ST_IDLE))
    else $error("result not presented");
`endif

endmodule

FILE: rtl/core/scim_dp.sv
module scim_dp
  import scim_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scim_cfg_t        cfg_i,
  input  scim_cmd_t        cmd_i,
  output scim_stat_t       stat_o,
  input  logic [COL_W-1:0] col_i,
  input  logic [ROW_W-1:0] row_i,
  input  logic [PIX_W-1:0] pix_i,
  output logic [PIX_W-1:0] pix_o
);

  function automatic logic [7:0] scale255(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [15:0] t;
    p = {8'd0, c} * {8'd0, a};
    t = p + {8'd0, p[15:8]} + 16'd1;
    return t[15:8];
  endfunction

  function automatic logic [1:0] mod3(input logic [IDX_W-1:0] i);
    logic [1:0] r;
    case (i)
      3'd0, 3'd3, 3'd6: r = 2'd0;
      3'd1, 3'd4, 3'd7: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  logic [PIX_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

  logic [CNT_W-1:0]  n_eff;
  logic [DIM_W-1:0]  w_eff, h_eff;
  logic              split;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [7:0]        dx, dy;
  logic [9:0]        sx, sy;
  logic              copy_in, orig_in;
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  rdata_q;
  logic              rd_orig_q, rd_copy_q, rd_in_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [PIX_W-1:0]  orig_q;
  logic [10:0]       sum_q [3];
  logic [PIX_W-1:0]  blended;
  logic [PIX_W-1:0]  pix_q;

  always_comb begin
    n_eff = (cfg_i.point_count > CNT_W'(MAX_COPIES)) ? CNT_W'(MAX_COPIES) : cfg_i.point_count;
    if (cfg_i.frame_width == '0) w_eff = DIM_W'(1);
    else if (cfg_i.frame_width > DIM_W'(MAX_WIDTH)) w_eff = DIM_W'(MAX_WIDTH);
    else w_eff = cfg_i.frame_width;
    if (cfg_i.frame_height == '0) h_eff = DIM_W'(1);
    else if (cfg_i.frame_height > DIM_W'(MAX_HEIGHT)) h_eff = DIM_W'(MAX_HEIGHT);
    else h_eff = cfg_i.frame_height;
  end

  assign stat_o.count = n_eff;
  assign split = cfg_i.color_split && (n_eff == CNT_W'(3) || n_eff == CNT_W'(6));

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      col_q <= col_i;
      row_q <= row_i;
    end
  end

  assign dx = cfg_i.x_offsets[{cmd_i.copy_idx, 3'b000} +: 8];
  assign dy = cfg_i.y_offsets[{cmd_i.copy_idx, 3'b000} +: 8];
  assign sx = {2'b00, col_q} - {{2{dx[7]}}, dx};
  assign sy = {2'b00, row_q} - {{2{dy[7]}}, dy};

  assign copy_in = !sx[9] && !sy[9] && (sx[8:0] < w_eff) && (sy[8:0] < h_eff);
  assign orig_in = ({1'b0, col_i} < w_eff) && ({1'b0, row_i} < h_eff);

  assign addr = (cmd_i.wr || cmd_i.start) ? {row_i, col_i} : {sy[7:0], sx[7:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[addr] <= pix_i;
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_orig_q <= 1'b0;
      rd_copy_q <= 1'b0;
      rd_in_q   <= 1'b0;
      rd_idx_q  <= '0;
    end else begin
      rd_orig_q <= cmd_i.start;
      rd_copy_q <= cmd_i.rd_copy;
      rd_in_q   <= cmd_i.start ? orig_in : copy_in;
      rd_idx_q  <= cmd_i.copy_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_orig_q) begin
      orig_q <= rd_in_q ? rdata_q : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd_i.start) begin
        sum_q[ch] <= '0;
      end else if (rd_copy_q && rd_in_q && (!split || mod3(rd_idx_q) == 2'(ch))) begin
        sum_q[ch] <= sum_q[ch] + 11'(scale255(rdata_q[8*ch +: 8], cfg_i.alpha));
      end
    end
  end

  always_comb begin
    logic [7:0] v, o;
    logic [8:0] s;
    blended = '0;
    for (int ch = 0; ch < 3; ch++) begin
      v = (sum_q[ch] > 11'd255) ? 8'hff : sum_q[ch][7:0];
      o = orig_q[8*ch +: 8];
      s = {1'b0, v} + {1'b0, o};
      case (cfg_i.output_blend)
        BLEND_REPLACE: blended[8*ch +: 8] = v;
        BLEND_ADD:     blended[8*ch +: 8] = s[8] ? 8'hff : s[7:0];
        default:       blended[8*ch +: 8] = {1'b0, v[7:1]} + {1'b0, o[7:1]};
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pix_q <= (n_eff == '0) ? orig_q : blended;
    end
  end

  assign pix_o = pix_q;

endmodule

FILE: rtl/core/shifted_copy_interference_mixer.sv
// Shifted-copy interference mixer.
// Input channel in_i (valid/ready): kind 0 writes pixel_in into the frame
// store at (col,row) and gives no result; kind 1 requests an output pixel at
// (col,row). Output channel out_o (valid/ready) carries one pixel_out beat per
// compute request, in request order.
// Config: APB registers at 8*i (point_count, color_split, alpha, x_offsets,
// y_offsets, frame_width, frame_height, output_blend); write only while idle.
// Sequence: a load is written on accept. A compute reads the original pixel
// on accept, then the n copies in turn, n = point_count capped at 8: the
// single-port frame memory serves one read per cycle; a flush state then
// drains the read and a done state blends and registers the result.
// Input is accepted again as soon as the result is registered.
// Reset clears control state and restores register defaults; the frame
// store is not cleared, so pixels must be loaded before they are read.
// A stalled receiver holds the result in the output register; loads are still
// taken, and a new compute waits in its final cycle until the beat is taken.
module shifted_copy_interference_mixer
  import scim_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  scim_in_if.sink            in_i,
  scim_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  scim_cfg_t  cfg;
  scim_cmd_t  cmd;
  scim_stat_t stat;

  scim_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scim_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  scim_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .stat_o (stat),
    .col_i  (in_i.col),
    .row_i  (in_i.row),
    .pix_i  (in_i.pixel_in),
    .pix_o  (out_o.pixel_out)
  );

endmodule
